/* rtl/unsigned_divide_128_defines.svh */
`ifndef UNSIGNED_DIVIDE_128_DEFINES_SVH
`define UNSIGNED_DIVIDE_128_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define UD128_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define UD128_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ud128_pkg.sv */
package ud128_pkg;

    localparam int HALF_W  = 64;
    localparam int WIDE_W  = 2 * HALF_W;
    localparam int TDATA_W = 4 * HALF_W;
    localparam int STEPS   = WIDE_W;
    localparam int CNT_W   = $clog2(STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic step;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic special;
    } t_status;

endpackage

/* rtl/ud128_ctrl.sv */
module ud128_ctrl
    import ud128_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_m_tready,
    input  t_status i_status,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    output t_cmd    o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_cnt       = CNT_W'(STEPS - 1);
                n_state     = i_status.special ? S_DONE : S_RUN;
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to be free or drained
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;

endmodule

/* rtl/ud128_dp.sv */
module ud128_dp
    import ud128_pkg::*;
(
    input  logic               i_clk,
    input  logic [TDATA_W-1:0] i_data,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic [TDATA_W-1:0] o_data,
    output logic               o_flag
);

    logic [WIDE_W-1:0]  r_nq;     // dividend, shifted out as quotient bits shift in
    logic [WIDE_W-1:0]  r_rem;
    logic [WIDE_W-1:0]  r_den;
    logic               r_flag;
    logic [TDATA_W-1:0] r_out_data;
    logic               r_out_flag;

    logic [WIDE_W:0]    cmp_diff;
    logic               op_eq, op_lt, op_dz;
    logic [WIDE_W-1:0]  shifted;
    logic [WIDE_W+1:0]  trial;
    logic               take;

    // operand classification
    assign cmp_diff = {1'b0, r_nq} - {1'b0, r_den};
    assign op_eq    = (r_nq == r_den);
    assign op_lt    = cmp_diff[WIDE_W];
    assign op_dz    = (r_den == '0);
    assign o_status.special = op_eq || op_lt || op_dz;

    // one restoring step: bring down the next dividend bit, try the subtract
    assign shifted = {r_rem[WIDE_W-2:0], r_nq[WIDE_W-1]};
    assign trial   = {1'b0, r_rem[WIDE_W-1], shifted} - {2'b00, r_den};
    assign take    = !trial[WIDE_W+1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_nq  <= {i_data[HALF_W-1:0], i_data[2*HALF_W-1:HALF_W]};
            r_den <= {i_data[3*HALF_W-1:2*HALF_W], i_data[4*HALF_W-1:3*HALF_W]};
        end
        if (i_cmd.check) begin
            if (op_eq) begin
                r_nq   <= WIDE_W'(1);
                r_rem  <= '0;
                r_flag <= 1'b0;
            end else if (op_lt) begin
                r_rem  <= r_nq;
                r_nq   <= '0;
                r_flag <= 1'b0;
            end else if (op_dz) begin
                r_nq   <= '1;
                r_rem  <= '1;
                r_flag <= 1'b1;
            end else begin
                r_rem  <= '0;
                r_flag <= 1'b0;
            end
        end
        if (i_cmd.step) begin
            r_nq  <= {r_nq[WIDE_W-2:0], take};
            r_rem <= take ? trial[WIDE_W-1:0] : shifted;
        end
        if (i_cmd.publish) begin
            r_out_data <= {r_rem[HALF_W-1:0], r_rem[WIDE_W-1:HALF_W],
                           r_nq[HALF_W-1:0], r_nq[WIDE_W-1:HALF_W]};
            r_out_flag <= r_flag;
        end
    end

    assign o_data = r_out_data;
    assign o_flag = r_out_flag;

endmodule

/* rtl/unsigned_divide_128.sv */
// Unsigned 128 by 128 bit divider. An item on the slave stream carries the
// dividend and divisor; one result item on the master stream carries the
// quotient, the remainder and a divide-by-zero flag. Equal operands give
// quotient 1 and remainder 0, a dividend below the divisor gives quotient 0
// with the dividend as remainder, and a zero divisor with nonzero dividend
// gives all ones in both and raises the flag. One item is worked at a time:
// an ordinary division passes through load, classify, 128 shift-and-subtract
// steps through the single 130-bit subtractor, one quotient bit per cycle,
// and a move into the output register once it is free or draining, before the
// next item can be taken; the special cases skip the steps. The output
// register lets a new item be accepted while the last result waits.
module unsigned_divide_128
    import ud128_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // dividend_high, dividend_low, divisor_high, divisor_low
    input  logic [TDATA_W-1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // quotient_high, quotient_low, remainder_high, remainder_low
    output logic [TDATA_W-1:0] m_axis_tdata,
    // divide_by_zero
    output logic               m_axis_tuser
);

    t_cmd    cmd;
    t_status status;

    ud128_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (status),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (cmd)
    );

    ud128_dp u_dp (
        .i_clk    (i_clk),
        .i_data   (s_axis_tdata),
        .i_cmd    (cmd),
        .o_status (status),
        .o_data   (m_axis_tdata),
        .o_flag   (m_axis_tuser)
    );

endmodule

/* rtl/ud128_checker.sv */
`include "unsigned_divide_128_defines.svh"

module ud128_checker
    import ud128_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser
);

    logic s_fire;
    logic data_ones;

    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign data_ones = (m_axis_tdata == '1);

    // flagged results carry all ones in quotient and remainder
    `UD128_ASSERT_NOW(a_dz_all_ones, m_axis_tvalid && m_axis_tuser, data_ones, "dz data not all ones")

    // block is busy right after taking an item
    `UD128_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_axis_tready, "ready right after accept")

    `UD128_ASSERT_NEXT(a_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "valid dropped")

endmodule

bind unsigned_divide_128 ud128_checker u_ud128_checker (.*);
